/* src/heliostat_mirror_aim_macros.svh */
// assertion helpers for the mirror aim block
`ifndef HELIOSTAT_MIRROR_AIM_MACROS_SVH
`define HELIOSTAT_MIRROR_AIM_MACROS_SVH

// property checked on every clock edge outside reset
`define HMA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define HMA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/hma_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hma_pkg
// shared constants, tables and types of the mirror aim pipeline
// ----------------------------------------------------------------------------
package hma_pkg;

    localparam int WORK_FRAC    = 30;
    localparam int ANG_FRAC     = 12;
    localparam int TABLE_LEN    = 32;
    localparam int FULL_TURN    = 36000;
    localparam int HALF_TURN    = 18000;
    localparam int QUARTER_TURN = 9000;
    localparam int ANG_W        = 15;
    localparam int STAT_W       = 2;
    localparam logic signed [63:0] CORDIC_GAIN_Q30 = 64'sd652032874;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_VERTICAL = 2'd1,
        STAT_ZERO_SUM = 2'd2
    } status_t;

    function automatic logic signed [31:0] atan_entry(input int i);
        logic signed [31:0] r;
        r = 32'sd0;
        case (i)
            0:  r = 32'sd18432000;
            1:  r = 32'sd10881045;
            2:  r = 32'sd5749245;
            3:  r = 32'sd2918407;
            4:  r = 32'sd1464867;
            5:  r = 32'sd733147;
            6:  r = 32'sd366663;
            7:  r = 32'sd183343;
            8:  r = 32'sd91673;
            9:  r = 32'sd45837;
            10: r = 32'sd22918;
            11: r = 32'sd11459;
            12: r = 32'sd5730;
            13: r = 32'sd2865;
            14: r = 32'sd1432;
            15: r = 32'sd716;
            16: r = 32'sd358;
            17: r = 32'sd179;
            18: r = 32'sd90;
            19: r = 32'sd45;
            20: r = 32'sd22;
            21: r = 32'sd11;
            22: r = 32'sd6;
            23: r = 32'sd3;
            24: r = 32'sd1;
            25: r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

/* src/heliostat_mirror_aim.sv */
`timescale 1ns / 1ps
// throughput: one request per cycle unless stalled; datapath is one stalled pipeline
// a full output register stalls every stage at once, so back pressure loses nothing
// reset: synchronous active-low aresetn clears the valid bits only
// ----------------------------------------------------------------------------
// heliostat_mirror_aim
// mirror normal pitch and yaw from sun and reflected ray directions
// ----------------------------------------------------------------------------
`include "heliostat_mirror_aim_macros.svh"

module heliostat_mirror_aim
    import hma_pkg::*;
#(
    parameter int VEC_FRAC_BITS = 16,
    parameter int CORDIC_STEPS  = 18
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sun_azimuth[15:0], sun_elevation[30:16], ray_azimuth[46:31], ray_elevation[61:47]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // mirror_yaw[14:0], mirror_pitch[29:15], status[31:30]
    output logic [31:0] m_tdata
);

    localparam int NSTEP = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int VW    = VEC_FRAC_BITS + 3;
    localparam int SW    = VEC_FRAC_BITS + 4;
    localparam int PW    = 2 * VW;
    localparam int HW    = 2 * SW + 1;
    localparam int RW    = SW;
    localparam int SC_LAT = NSTEP + 3;
    localparam int AT_LAT = NSTEP + 3;
    // sincos, multiply, sum, square, sqrt, atan2
    localparam int LAT   = SC_LAT + 1 + 1 + 1 + RW + AT_LAT;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vld_reg[LAT-1];
        end
    end

    // input angles
    logic signed [16:0] ang [4];
    assign ang[0] = signed'({1'b0, s_tdata[15:0]});
    assign ang[1] = 17'(signed'(s_tdata[30:16]));
    assign ang[2] = signed'({1'b0, s_tdata[46:31]});
    assign ang[3] = 17'(signed'(s_tdata[61:47]));

    logic signed [VW-1:0] sn [4];
    logic signed [VW-1:0] cs [4];

    for (genvar k = 0; k < 4; k++) begin : g_sc
        hma_sincos #(
            .VEC_FRAC_BITS (VEC_FRAC_BITS),
            .CORDIC_STEPS  (CORDIC_STEPS),
            .VEC_W         (VW)
        ) u_sc (
            .aclk    (aclk),
            .en      (en),
            .angle   (ang[k]),
            .sin_out (sn[k]),
            .cos_out (cs[k])
        );
    end

    // direction products
    logic signed [PW-1:0] p_reg [4];
    logic signed [VW-1:0] se_reg [2];

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0]  <= PW'(cs[1]) * PW'(sn[0]);
            p_reg[1]  <= PW'(cs[1]) * PW'(cs[0]);
            p_reg[2]  <= PW'(cs[3]) * PW'(sn[2]);
            p_reg[3]  <= PW'(cs[3]) * PW'(cs[2]);
            se_reg[0] <= sn[1];
            se_reg[1] <= sn[3];
        end
    end

    logic signed [PW-1:0] pr [4];
    for (genvar k = 0; k < 4; k++) begin : g_rnd
        assign pr[k] = (p_reg[k] + (PW'(1) <<< (VEC_FRAC_BITS - 1))) >>> VEC_FRAC_BITS;
    end

    logic signed [SW-1:0] nx_reg, ny_reg, nz_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg <= SW'(pr[0]) + SW'(pr[2]);
            ny_reg <= SW'(pr[1]) + SW'(pr[3]);
            nz_reg <= SW'(se_reg[0]) + SW'(se_reg[1]);
        end
    end

    // square stage
    logic [HW-1:0]        hh_reg;
    logic signed [SW-1:0] sx_reg, sy_reg, sz_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            hh_reg <= HW'(nx_reg * nx_reg) + HW'(ny_reg * ny_reg);
            sx_reg <= nx_reg;
            sy_reg <= ny_reg;
            sz_reg <= nz_reg;
        end
    end

    // integer square root, one result bit per stage
    logic [HW+1:0]        rem_reg [RW+1];
    logic [RW-1:0]        root_reg [RW+1];
    logic signed [SW-1:0] qx_reg [RW+1];
    logic signed [SW-1:0] qy_reg [RW+1];
    logic signed [SW-1:0] qz_reg [RW+1];

    always_comb begin
        rem_reg[0]  = {2'b00, hh_reg};
        root_reg[0] = '0;
        qx_reg[0]   = sx_reg;
        qy_reg[0]   = sy_reg;
        qz_reg[0]   = sz_reg;
    end

    for (genvar i = 0; i < RW; i++) begin : g_sqrt
        localparam int B = RW - 1 - i;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_reg[i] >= ((HW+2)'(root_reg[i]) << (B + 1)) + ((HW+2)'(1) << (2 * B)))
                begin
                    rem_reg[i+1]  <= rem_reg[i] - (((HW+2)'(root_reg[i]) << (B + 1))
                                     + ((HW+2)'(1) << (2 * B)));
                    root_reg[i+1] <= root_reg[i] | (RW'(1) << B);
                end else begin
                    rem_reg[i+1]  <= rem_reg[i];
                    root_reg[i+1] <= root_reg[i];
                end
                qx_reg[i+1] <= qx_reg[i];
                qy_reg[i+1] <= qy_reg[i];
                qz_reg[i+1] <= qz_reg[i];
            end
        end
    end

    logic signed [SW-1:0] h_val, ax_val;
    assign h_val  = SW'(root_reg[RW]);
    assign ax_val = qx_reg[RW] < 0 ? -qx_reg[RW] : qx_reg[RW];

    logic [ANG_W-1:0] pitch_w, yaw_w;

    hma_atan2 #(
        .VEC_FRAC_BITS (VEC_FRAC_BITS),
        .CORDIC_STEPS  (CORDIC_STEPS),
        .IN_W          (SW)
    ) u_pitch (
        .aclk      (aclk),
        .en        (en),
        .y_in      (h_val),
        .x_in      (qz_reg[RW]),
        .angle_out (pitch_w)
    );

    hma_atan2 #(
        .VEC_FRAC_BITS (VEC_FRAC_BITS),
        .CORDIC_STEPS  (CORDIC_STEPS),
        .IN_W          (SW)
    ) u_yaw (
        .aclk      (aclk),
        .en        (en),
        .y_in      (ax_val),
        .x_in      (qy_reg[RW]),
        .angle_out (yaw_w)
    );

    // status follows the atan2 latency
    status_t st_next;
    status_t st_reg [AT_LAT+1];
    always_comb begin
        if (qx_reg[RW] == 0 && qy_reg[RW] == 0 && qz_reg[RW] == 0) begin
            st_next = STAT_ZERO_SUM;
        end else if (qx_reg[RW] == 0 && qy_reg[RW] == 0) begin
            st_next = STAT_VERTICAL;
        end else begin
            st_next = STAT_OK;
        end
    end
    assign st_reg[0] = st_next;
    for (genvar i = 0; i < AT_LAT; i++) begin : g_st
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[i+1] <= st_reg[i];
            end
        end
    end

    logic [31:0] out_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            if (st_reg[AT_LAT] == STAT_OK) begin
                out_reg <= {STAT_OK, pitch_w, yaw_w};
            end else begin
                out_reg <= {st_reg[AT_LAT], {ANG_W{1'b0}}, {ANG_W{1'b0}}};
            end
        end
    end
    assign m_tdata = out_reg;

    `HMA_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped under stall")
    `HMA_ASSERT(a_stat, aclk, aresetn, m_tvalid |-> m_tdata[31:30] != 2'd3, "bad status code")
    `HMA_ASSERT(a_zero, aclk, aresetn, m_tvalid && m_tdata[31:30] != 2'd0 |-> m_tdata[29:0] == 30'd0, "flagged result has angles")
    `HMA_ASSERT(a_rdy, aclk, aresetn, s_tready == (!m_tvalid || m_tready), "ready not tied to output stage")
    `HMA_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

/* src/hma_sincos.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hma_sincos
// pipelined rotation cordic: angle in hundredths of a degree to sin and cos
// ----------------------------------------------------------------------------
module hma_sincos
    import hma_pkg::*;
#(
    parameter int VEC_FRAC_BITS = 16,
    parameter int CORDIC_STEPS  = 18,
    parameter int VEC_W         = VEC_FRAC_BITS + 3
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [16:0]      angle,
    output logic signed [VEC_W-1:0] sin_out,
    output logic signed [VEC_W-1:0] cos_out
);

    localparam int NSTEP = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int SH    = WORK_FRAC - VEC_FRAC_BITS;

    // fold stages
    logic signed [16:0] mod_next;
    logic [15:0]        mod_reg;
    logic [13:0]        base_next;
    logic               sneg_next, cneg_next;

    logic signed [33:0] x_reg [NSTEP+1];
    logic signed [33:0] y_reg [NSTEP+1];
    logic signed [29:0] z_reg [NSTEP+1];
    logic               sn_reg [NSTEP+1];
    logic               cn_reg [NSTEP+1];

    always_comb begin
        mod_next = angle;
        if (mod_next >= 17'sd36000) begin
            mod_next = mod_next - 17'sd36000;
        end
        if (mod_next < 17'sd0) begin
            mod_next = mod_next + 17'sd36000;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mod_reg <= mod_next[15:0];
        end
    end

    always_comb begin
        base_next = mod_reg[13:0];
        sneg_next = 1'b0;
        cneg_next = 1'b0;
        if (mod_reg <= 16'(QUARTER_TURN)) begin
            base_next = mod_reg[13:0];
        end else if (mod_reg <= 16'(HALF_TURN)) begin
            base_next = 14'(16'(HALF_TURN) - mod_reg);
            cneg_next = 1'b1;
        end else if (mod_reg <= 16'(HALF_TURN + QUARTER_TURN)) begin
            base_next = 14'(mod_reg - 16'(HALF_TURN));
            sneg_next = 1'b1;
            cneg_next = 1'b1;
        end else begin
            base_next = 14'(16'(FULL_TURN) - mod_reg);
            sneg_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]  <= 34'(CORDIC_GAIN_Q30);
            y_reg[0]  <= '0;
            z_reg[0]  <= 30'(signed'({1'b0, base_next}) <<< ANG_FRAC);
            sn_reg[0] <= sneg_next;
            cn_reg[0] <= cneg_next;
        end
    end

    for (genvar i = 0; i < NSTEP; i++) begin : g_rot
        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - 30'(atan_entry(i));
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + 30'(atan_entry(i));
                end
                sn_reg[i+1] <= sn_reg[i];
                cn_reg[i+1] <= cn_reg[i];
            end
        end
    end

    logic signed [33:0] s_rnd, c_rnd;
    always_comb begin
        if (SH == 0) begin
            s_rnd = y_reg[NSTEP];
            c_rnd = x_reg[NSTEP];
        end else begin
            s_rnd = (y_reg[NSTEP] + (34'sd1 <<< (SH - 1))) >>> SH;
            c_rnd = (x_reg[NSTEP] + (34'sd1 <<< (SH - 1))) >>> SH;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_out <= sn_reg[NSTEP] ? -VEC_W'(s_rnd) : VEC_W'(s_rnd);
            cos_out <= cn_reg[NSTEP] ? -VEC_W'(c_rnd) : VEC_W'(c_rnd);
        end
    end

endmodule

/* src/hma_atan2.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hma_atan2
// pipelined vectoring cordic: atan2 for y >= 0 in hundredths of a degree
// ----------------------------------------------------------------------------
module hma_atan2
    import hma_pkg::*;
#(
    parameter int VEC_FRAC_BITS = 16,
    parameter int CORDIC_STEPS  = 18,
    parameter int IN_W          = VEC_FRAC_BITS + 4
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [IN_W-1:0] y_in,
    input  logic signed [IN_W-1:0] x_in,
    output logic [ANG_W-1:0]       angle_out
);

    localparam int NSTEP = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int SH    = WORK_FRAC - VEC_FRAC_BITS;
    localparam int W     = IN_W + SH + 2;

    logic signed [W-1:0]  x_reg [NSTEP+1];
    logic signed [W-1:0]  y_reg [NSTEP+1];
    logic signed [31:0]   z_reg [NSTEP+1];
    logic                 neg_reg [NSTEP+1];
    logic signed [31:0]   zf_reg;
    logic signed [31:0]   zf;
    logic signed [31:0]   zr;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= W'(x_in < 0 ? -x_in : x_in) <<< SH;
            y_reg[0]   <= W'(y_in) <<< SH;
            z_reg[0]   <= '0;
            neg_reg[0] <= x_in < 0;
        end
    end

    for (genvar i = 0; i < NSTEP; i++) begin : g_vec
        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    assign zf = neg_reg[NSTEP] ? (32'(HALF_TURN) <<< ANG_FRAC) - z_reg[NSTEP]
                               : z_reg[NSTEP];

    always_ff @(posedge aclk) begin
        if (en) begin
            zf_reg <= zf;
        end
    end

    assign zr = (zf_reg + (32'sd1 <<< (ANG_FRAC - 1))) >>> ANG_FRAC;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (zr < 0) begin
                angle_out <= '0;
            end else if (zr > 32'(HALF_TURN)) begin
                angle_out <= ANG_W'(HALF_TURN);
            end else begin
                angle_out <= zr[ANG_W-1:0];
            end
        end
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mirror aim regression bench
// drives random and corner sun and ray directions into the aim pipeline with
// random gaps and back pressure, predicts yaw, pitch and status in fixed
// point and checks every result request in order
// ----------------------------------------------------------------------------
module testbench;
    import hma_pkg::*;

    localparam int VFB   = 16;
    localparam int STEPS = 18;
    localparam int LAT   = 2 * STEPS + VFB + 14;

    typedef struct packed {
        logic [14:0] yaw;
        logic [14:0] pitch;
        status_t     status;
    } aim_t;

    function automatic longint rnd_shift(longint v, int s);
        if (s == 0) return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint atan_of(int i);
        longint t [0:31];
        t = '{18432000, 10881045, 5749245, 2918407, 1464867, 733147, 366663, 183343,
              91673, 45837, 22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45,
              22, 11, 6, 3, 1, 1, 0, 0, 0, 0, 0, 0};
        return t[i];
    endfunction

    task automatic base_sincos(int b, output longint s, output longint c);
        longint x, y, z, dx, dy;
        x = 652032874; y = 0; z = longint'(b) <<< 12;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_of(i);
            end else begin
                x += dx; y -= dy; z += atan_of(i);
            end
        end
        s = rnd_shift(y, 30 - VFB);
        c = rnd_shift(x, 30 - VFB);
    endtask

    task automatic any_sincos(int a, output longint s, output longint c);
        int r;
        longint bs, bc;
        r = a % 36000;
        if (r < 0) r += 36000;
        if (r <= 9000) begin
            base_sincos(r, bs, bc); s = bs; c = bc;
        end else if (r <= 18000) begin
            base_sincos(18000 - r, bs, bc); s = bs; c = -bc;
        end else if (r <= 27000) begin
            base_sincos(r - 18000, bs, bc); s = -bs; c = -bc;
        end else begin
            base_sincos(36000 - r, bs, bc); s = -bs; c = bc;
        end
    endtask

    task automatic unit_dir(int az, int el, output longint vx, output longint vy,
                            output longint vz);
        longint sa, ca, se, ce;
        any_sincos(az, sa, ca);
        any_sincos(el, se, ce);
        vx = rnd_shift(ce * sa, VFB);
        vy = rnd_shift(ce * ca, VFB);
        vz = se;
    endtask

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint vec_angle(longint y, longint x);
        longint z, dx, dy;
        z = 0; x = x <<< (30 - VFB); y = y <<< (30 - VFB);
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += atan_of(i);
            end else begin
                x -= dx; y += dy; z -= atan_of(i);
            end
        end
        return z;
    endfunction

    function automatic logic [14:0] half_turn_angle(longint y, longint x);
        longint z;
        if (x >= 0) z = vec_angle(y, x);
        else z = (longint'(18000) <<< 12) - vec_angle(y, -x);
        z = rnd_shift(z, 12);
        if (z < 0) z = 0;
        if (z > 18000) z = 18000;
        return z[14:0];
    endfunction

    task automatic predict_aim(logic [63:0] d, output aim_t r);
        longint ux, uy, uz, wx, wy, wz, nx, ny, nz, h;
        unit_dir(int'(d[15:0]), int'($signed(d[30:16])), ux, uy, uz);
        unit_dir(int'(d[46:31]), int'($signed(d[61:47])), wx, wy, wz);
        nx = ux + wx; ny = uy + wy; nz = uz + wz;
        r = '0;
        if (nx == 0 && ny == 0 && nz == 0) begin
            r.status = STAT_ZERO_SUM;
        end else if (nx == 0 && ny == 0) begin
            r.status = STAT_VERTICAL;
        end else begin
            r.status = STAT_OK;
            h = int_sqrt(longint'(nx * nx + ny * ny));
            r.pitch = half_turn_angle(h, nz);
            r.yaw = half_turn_angle(nx < 0 ? -nx : nx, ny);
        end
    endtask

    class aim_scoreboard;
        aim_t pending[$];
        int errors = 0;

        function void note_request(aim_t e);
            pending.push_back(e);
        endfunction

        function void check_result(logic [31:0] d);
            aim_t e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %h", $time, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[14:0] !== e.yaw) begin
                $display("%0t yaw exp %0d got %0d", $time, e.yaw, d[14:0]);
                errors++;
            end
            if (d[29:15] !== e.pitch) begin
                $display("%0t pitch exp %0d got %0d", $time, e.pitch, d[29:15]);
                errors++;
            end
            if (d[31:30] !== e.status) begin
                $display("%0t status exp %0d got %0d", $time, e.status, d[31:30]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic        stim_done = 0;

    aim_scoreboard sb = new();

    heliostat_mirror_aim #(.VEC_FRAC_BITS(VFB), .CORDIC_STEPS(STEPS)) u_dut (.*);

    initial forever #4 aclk = ~aclk;

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] pack_dirs(int sa, int se, int ra, int re);
        logic [15:0] a1, a2;
        logic [14:0] e1, e2;
        a1 = sa[15:0]; e1 = se[14:0]; a2 = ra[15:0]; e2 = re[14:0];
        return {2'b00, e2, a2, e1, a1};
    endfunction

    task automatic send_request(logic [63:0] d);
        aim_t e;
        int g;
        g = gap_len();
        if (g != 0) begin
            s_tvalid <= 0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_aim(d, e);
        sb.note_request(e);
        @(negedge aclk);
    endtask

    initial begin
        int sa, se, ra, re;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        send_request(pack_dirs(0, -9000, 0, -9000));
        send_request(pack_dirs(35999, 9000, 35999, 9000));
        send_request(pack_dirs(0, 4500, 18000, -4500));
        send_request(pack_dirs(9000, 0, 27000, 0));
        send_request(pack_dirs(1234, 0, 1234, 0));
        send_request(pack_dirs(0, 9000, 18000, 9000));
        send_request(pack_dirs(9000, 3000, 27000, 3000));
        send_request(pack_dirs(65535, 16383, 65535, -16384));
        send_request(pack_dirs(36000, -16384, 40000, 16383));
        send_request(pack_dirs(0, 0, 0, 18000));
        send_request(pack_dirs(27000, 2000, 9000, 7000));
        send_request(pack_dirs(18000, 4500, 0, 4500));
        send_request(pack_dirs(45000, 9000, 30000, -9000));
        for (int n = 0; n < 1900; n++) begin
            int p;
            p = $urandom_range(0, 9);
            if (p < 7) begin
                sa = $urandom_range(0, 35999); se = $urandom_range(0, 18000) - 9000;
                ra = $urandom_range(0, 35999); re = $urandom_range(0, 18000) - 9000;
            end else if (p < 9) begin
                sa = $urandom_range(0, 35999); se = $urandom_range(0, 18000) - 9000;
                ra = (sa + 18000) % 36000; re = -se;
                if (p == 8) re = se;
            end else begin
                sa = $urandom_range(0, 65535); se = $urandom_range(0, 32767) - 16384;
                ra = $urandom_range(0, 65535); re = $urandom_range(0, 32767) - 16384;
            end
            send_request(pack_dirs(sa, se, ra, re));
        end
        s_tvalid <= 0;
        stim_done = 1;
    end

    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            g = gap_len();
            if (g == 0) begin
                m_tready <= 1;
            end else begin
                m_tready <= 0;
                repeat (g - 1) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LAT + 100) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
